FILE: hdl/mdm_pkg.sv
// shared constants, types and wheel direction codes for the mecanum drive mixer
package mdm_pkg;

  localparam int BASE_W  = 9;
  localparam int AXIS_W  = 11;
  localparam int CFG_W   = 8;
  localparam int IDX_W   = 2;
  localparam int MAG_W   = 10;
  localparam int PROD_W  = MAG_W + CFG_W;
  localparam int RECIP_W = 19;
  localparam int PM_W    = PROD_W + RECIP_W;
  localparam int QUOT_W  = 10;
  localparam int WHEEL_W = 12;
  localparam int DUTY_W  = 8;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 40;

  localparam int AXIS_DEADBAND = 30;
  localparam int AXIS_SPAN     = 482;
  localparam int SPEED_LIMIT   = 255;

  // divide by AXIS_SPAN as multiply by rounded-up reciprocal, exact for products below 2**18
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP_MUL   = ((2 ** RECIP_SHIFT) + AXIS_SPAN - 1) / AXIS_SPAN;

  localparam logic [CFG_W-1:0] STEER_GAIN_RST      = 8'd75;
  localparam logic [CFG_W-1:0] SHIFT_SPEED_RST     = 8'd100;
  localparam logic [CFG_W-1:0] STEER_MIN_SPEED_RST = 8'd25;

  typedef enum logic [IDX_W-1:0] {
    REG_STEER_GAIN      = 2'd0,
    REG_SHIFT_SPEED     = 2'd1,
    REG_STEER_MIN_SPEED = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef struct packed {
    dir_e              dir;
    logic [DUTY_W-1:0] duty;
  } wheel_cmd_t;

endpackage

FILE: hdl/mdm_wheel_out.sv
// saturates one wheel speed to the motor limit and splits it into direction and duty
module mdm_wheel_out (
  input  logic signed [mdm_pkg::WHEEL_W-1:0] speed_i,
  output mdm_pkg::wheel_cmd_t                cmd_o
);
  import mdm_pkg::*;

  localparam logic signed [WHEEL_W-1:0] LimPos = WHEEL_W'(SPEED_LIMIT);
  localparam logic signed [WHEEL_W-1:0] LimNeg = -WHEEL_W'(SPEED_LIMIT);

  logic signed [WHEEL_W-1:0] sat;
  logic signed [WHEEL_W-1:0] neg;

  always_comb begin
    if (speed_i > LimPos) begin
      sat = LimPos;
    end else if (speed_i < LimNeg) begin
      sat = LimNeg;
    end else begin
      sat = speed_i;
    end
    neg = -sat;
    if (sat > 0) begin
      cmd_o.dir  = DIR_FWD;
      cmd_o.duty = sat[DUTY_W-1:0];
    end else if (sat < 0) begin
      cmd_o.dir  = DIR_REV;
      cmd_o.duty = neg[DUTY_W-1:0];
    end else begin
      cmd_o.dir  = DIR_STOP;
      cmd_o.duty = '0;
    end
  end

endmodule

FILE: hdl/mecanum_drive_mixer.sv
// mecanum drive mixer: one drive command beat in, four wheel commands in one beat out
// throughput: one beat per cycle while the output is not stalled; five register stages
//   (deadband, gain multiply, reciprocal multiply for the span divide, wheel mixing,
//   saturation), each advancing whenever it is empty or the next one can take its beat
// a stalled output holds the pipeline back stage by stage without dropping beats
// reset clears all stage valid bits and loads the default gain, shift speed and threshold
module mecanum_drive_mixer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mdm_pkg::IDX_W-1:0]     cfg_index_i,
  input  logic [mdm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // base_speed[8:0], steer_axis[19:9], left_bumper[20], right_bumper[21], zero[23:22]
  input  logic [mdm_pkg::IN_W-1:0]      s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // front_left_dir[1:0], front_left_duty[9:2], front_right_dir[11:10],
  // front_right_duty[19:12], rear_left_dir[21:20], rear_left_duty[29:22],
  // rear_right_dir[31:30], rear_right_duty[39:32]
  output logic [mdm_pkg::OUT_W-1:0]     m_axis_tdata
);
  import mdm_pkg::*;

  localparam logic [RECIP_W-1:0] Recip = RECIP_W'(RECIP_MUL);

  // configuration registers
  logic [CFG_W-1:0] gain_q, shift_q, min_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= STEER_GAIN_RST;
      shift_q <= SHIFT_SPEED_RST;
      min_q   <= STEER_MIN_SPEED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STEER_GAIN:      gain_q  <= cfg_data_i;
        REG_SHIFT_SPEED:     shift_q <= cfg_data_i;
        REG_STEER_MIN_SPEED: min_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: magnitudes, deadband and steering enable
  logic signed [BASE_W-1:0] base_in;
  logic signed [AXIS_W-1:0] axis_in;
  logic [BASE_W-1:0]        abs_base;
  logic [AXIS_W-1:0]        abs_axis;
  logic [AXIS_W-1:0]        axis_off;
  logic                     steer_en, base_pos_d;
  logic [MAG_W-1:0]         mag_d;

  always_comb begin
    base_in    = $signed(s_axis_tdata[BASE_W-1:0]);
    axis_in    = $signed(s_axis_tdata[BASE_W+AXIS_W-1:BASE_W]);
    abs_base   = base_in[BASE_W-1] ? BASE_W'(-base_in) : BASE_W'(base_in);
    abs_axis   = axis_in[AXIS_W-1] ? AXIS_W'(-axis_in) : AXIS_W'(axis_in);
    steer_en   = (axis_in != '0) && (abs_base > BASE_W'(min_q)) &&
                 (abs_axis >= AXIS_W'(AXIS_DEADBAND));
    axis_off   = abs_axis - AXIS_W'(AXIS_DEADBAND);
    mag_d      = steer_en ? axis_off[MAG_W-1:0] : '0;
    base_pos_d = !base_in[BASE_W-1] && (base_in != '0);
  end

  logic [MAG_W-1:0]         mag1_q;
  logic signed [BASE_W-1:0] base1_q;
  logic                     pos1_q, sneg1_q, lb1_q, rb1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag1_q  <= mag_d;
      base1_q <= base_in;
      pos1_q  <= base_pos_d;
      sneg1_q <= axis_in[AXIS_W-1] ^ !base_pos_d;
      lb1_q   <= s_axis_tdata[BASE_W+AXIS_W];
      rb1_q   <= s_axis_tdata[BASE_W+AXIS_W+1];
    end
  end

  // stage 2: gain multiply
  logic [PROD_W-1:0]        p2_q;
  logic signed [BASE_W-1:0] base2_q;
  logic                     pos2_q, sneg2_q, lb2_q, rb2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      p2_q    <= PROD_W'(mag1_q) * PROD_W'(gain_q);
      base2_q <= base1_q;
      pos2_q  <= pos1_q;
      sneg2_q <= sneg1_q;
      lb2_q   <= lb1_q;
      rb2_q   <= rb1_q;
    end
  end

  // stage 3: reciprocal multiply for the span divide
  logic [PM_W-1:0]          pm3_q;
  logic [PROD_W-1:0]        p3_q;
  logic signed [BASE_W-1:0] base3_q;
  logic                     pos3_q, sneg3_q, lb3_q, rb3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      pm3_q   <= PM_W'(p2_q) * PM_W'(Recip);
      p3_q    <= p2_q;
      base3_q <= base2_q;
      pos3_q  <= pos2_q;
      sneg3_q <= sneg2_q;
      lb3_q   <= lb2_q;
      rb3_q   <= rb2_q;
    end
  end

  // stage 4: steering term, bumper shift and wheel mixing
  logic [QUOT_W-1:0]         quot;
  logic signed [WHEEL_W-1:0] steer, shv, tilt, base_w;
  logic signed [WHEEL_W-1:0] fl_d, fr_d, rl_d, rr_d;

  always_comb begin
    quot   = pm3_q[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
    steer  = sneg3_q ? -$signed(WHEEL_W'(quot)) : $signed(WHEEL_W'(quot));
    shv    = pos3_q ? $signed(WHEEL_W'(shift_q)) : -$signed(WHEEL_W'(shift_q));
    // left bumper wins over right
    priority if (lb3_q) begin
      tilt = shv;
    end else if (rb3_q) begin
      tilt = -shv;
    end else begin
      tilt = '0;
    end
    base_w = WHEEL_W'(base3_q);
    fl_d   = base_w + steer + tilt;
    fr_d   = base_w - steer - tilt;
    rl_d   = base_w + steer - tilt;
    rr_d   = base_w - steer + tilt;
  end

  logic signed [WHEEL_W-1:0] fl4_q, fr4_q, rl4_q, rr4_q;
  logic [PROD_W-1:0]         p4_q;
  logic [QUOT_W-1:0]         q4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      fl4_q <= fl_d;
      fr4_q <= fr_d;
      rl4_q <= rl_d;
      rr4_q <= rr_d;
      p4_q  <= p3_q;
      q4_q  <= quot;
    end
  end

  // stage 5: saturation and direction coding
  wheel_cmd_t fl_cmd, fr_cmd, rl_cmd, rr_cmd;
  wheel_cmd_t fl5_q, fr5_q, rl5_q, rr5_q;

  mdm_wheel_out u_fl (.speed_i(fl4_q), .cmd_o(fl_cmd));
  mdm_wheel_out u_fr (.speed_i(fr4_q), .cmd_o(fr_cmd));
  mdm_wheel_out u_rl (.speed_i(rl4_q), .cmd_o(rl_cmd));
  mdm_wheel_out u_rr (.speed_i(rr4_q), .cmd_o(rr_cmd));

  always_ff @(posedge clk_i) begin
    if (en5) begin
      fl5_q <= fl_cmd;
      fr5_q <= fr_cmd;
      rl5_q <= rl_cmd;
      rr5_q <= rr_cmd;
    end
  end

  assign m_axis_tdata = {rr5_q.duty, rr5_q.dir, rl5_q.duty, rl5_q.dir,
                         fr5_q.duty, fr5_q.dir, fl5_q.duty, fl5_q.dir};

`ifndef ASSERT_OFF
  // input side only stalls when the output beat is held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output side is free");

  // first stage only fills from an accepted input beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(v1_q) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("stage one filled without an input beat");

  // reciprocal multiply gives the exact truncated quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ((19'(q4_q) * 19'(AXIS_SPAN)) <= 19'(p4_q)) &&
             (19'(p4_q) < ((19'(q4_q) + 19'd1) * 19'(AXIS_SPAN))))
    else $error("span divide quotient off");

  // duty is zero exactly when the wheel is stopped, checked for the front left and rear right wheels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((fl5_q.dir == DIR_STOP) == (fl5_q.duty == '0)) &&
                      ((rr5_q.dir == DIR_STOP) == (rr5_q.duty == '0)))
    else $error("stop code and duty disagree");
`endif

endmodule

FILE: tb/mdm_wheel_checker.sv
`timescale 1ns / 1ps
// checker for the mecanum drive mixer: follows register writes, predicts and compares wheel beats
module mdm_wheel_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [mdm_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [mdm_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      cmd_valid_i,
  input  logic                      cmd_ready_i,
  input  logic [mdm_pkg::IN_W-1:0]  cmd_data_i,
  input  logic                      whl_valid_i,
  input  logic                      whl_ready_i,
  input  logic [mdm_pkg::OUT_W-1:0] whl_data_i,
  output int                        pending_o,
  output int                        fail_count_o
);
  import mdm_pkg::*;

  localparam int DEADBAND  = 30;
  localparam int SPAN      = 482;
  localparam int WHEEL_MAX = 255;

  // wheel order matches the output beat: front left, front right, rear left, rear right
  localparam int FL = 0;
  localparam int FR = 1;
  localparam int RL = 2;
  localparam int RR = 3;

  typedef wheel_cmd_t [3:0] wheel_set_t;

  logic [CFG_W-1:0] gain_q;
  logic [CFG_W-1:0] shift_q;
  logic [CFG_W-1:0] min_speed_q;
  wheel_set_t       wheel_cmds_due[$];
  int               fails = 0;

  function automatic wheel_cmd_t to_wheel(input int spd);
    wheel_cmd_t cmd;
    if (spd > WHEEL_MAX) spd = WHEEL_MAX;
    else if (spd < -WHEEL_MAX) spd = -WHEEL_MAX;
    if (spd > 0) begin
      cmd.dir  = DIR_FWD;
      cmd.duty = spd[DUTY_W-1:0];
    end else if (spd < 0) begin
      cmd.dir  = DIR_REV;
      cmd.duty = DUTY_W'(-spd);
    end else begin
      cmd.dir  = DIR_STOP;
      cmd.duty = '0;
    end
    return cmd;
  endfunction

  function automatic wheel_set_t mix_wheels(input logic [IN_W-1:0] word);
    int         base_v;
    int         axis_v;
    int         abs_b;
    int         abs_a;
    int         steer;
    int         shove;
    int         spd [4];
    wheel_set_t res;
    base_v = $signed(word[8:0]);
    axis_v = $signed(word[19:9]);
    abs_b  = base_v < 0 ? -base_v : base_v;
    abs_a  = axis_v < 0 ? -axis_v : axis_v;
    for (int k = 0; k < 4; k++) spd[k] = base_v;
    if (axis_v != 0 && abs_b > int'(min_speed_q) && abs_a >= DEADBAND) begin
      steer = (abs_a - DEADBAND) * int'(gain_q) / SPAN;
      if (axis_v < 0) steer = -steer;
      if (base_v <= 0) steer = -steer;
      spd[FL] += steer;
      spd[FR] -= steer;
      spd[RL] += steer;
      spd[RR] -= steer;
    end
    // bumper shift flips sign when not driving forward, zero speed included
    if (word[20] || word[21]) begin
      shove = base_v > 0 ? int'(shift_q) : -int'(shift_q);
      if (word[20]) begin
        spd[FL] += shove;
        spd[FR] -= shove;
        spd[RL] -= shove;
        spd[RR] += shove;
      end else begin
        spd[FL] -= shove;
        spd[FR] += shove;
        spd[RL] += shove;
        spd[RR] -= shove;
      end
    end
    for (int k = 0; k < 4; k++) res[k] = to_wheel(spd[k]);
    return res;
  endfunction

  function automatic string wheel_label(input int k);
    case (k)
      FL:      return "front_left";
      FR:      return "front_right";
      RL:      return "rear_left";
      default: return "rear_right";
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_set_t  due;
    logic [9:0]  got;
    if (!rst_ni) begin
      gain_q      = STEER_GAIN_RST;
      shift_q     = SHIFT_SPEED_RST;
      min_speed_q = STEER_MIN_SPEED_RST;
      wheel_cmds_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_STEER_GAIN:      gain_q      = cfg_data_i;
          REG_SHIFT_SPEED:     shift_q     = cfg_data_i;
          REG_STEER_MIN_SPEED: min_speed_q = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_valid_i && cmd_ready_i) wheel_cmds_due.push_back(mix_wheels(cmd_data_i));
      if (whl_valid_i && whl_ready_i) begin
        if (wheel_cmds_due.size() == 0) begin
          $error("wheel beat with no drive command pending");
          fails++;
        end else begin
          due = wheel_cmds_due.pop_front();
          for (int k = 0; k < 4; k++) begin
            got = whl_data_i[10*k +: 10];
            check_field({wheel_label(k), "_dir"}, 8'(due[k].dir), 8'(got[1:0]));
            check_field({wheel_label(k), "_duty"}, due[k].duty, got[9:2]);
          end
        end
      end
    end
    pending_o    = wheel_cmds_due.size();
    fail_count_o = fails;
  end

endmodule

FILE: tb/mecanum_drive_mixer_test.sv
`timescale 1ns / 1ps
// testbench top for the mecanum drive mixer: drive commands, register writes and the verdict
module mecanum_drive_mixer_test;
  import mdm_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_CMDS  = 330;
  localparam int HOLD_CYCLES = 64;

  // index with no register behind it, writes to it must be dropped
  localparam logic [IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_index_i   = '0;
  logic [CFG_W-1:0] cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  int pending;
  int fail_count;
  int cycle_count    = 0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;
  int hold_left      = 0;

  mecanum_drive_mixer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  mdm_wheel_checker i_wheel_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .whl_valid_i  (m_axis_tvalid),
    .whl_ready_i  (m_axis_tready),
    .whl_data_i   (m_axis_tdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // wheel side: random stalls, plus a long hold-off when asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_cmd(input int b, input int a, input int lb,
                                               input int rb);
    return {{(IN_W-22){1'b0}}, rb[0], lb[0], a[10:0], b[8:0]};
  endfunction

  function automatic logic [IN_W-1:0] rand_cmd();
    int b;
    int a;
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       b = -256;
        1:       b = -255;
        2:       b = 255;
        default: b = 0;
      endcase
    end else begin
      b = int'($urandom_range(511)) - 256;
    end
    case ($urandom_range(7))
      0:       a = int'($urandom_range(2047)) - 1024;
      1:       a = int'($urandom_range(64)) - 32;
      default: a = int'($urandom_range(1024)) - 512;
    endcase
    return pack_cmd(b, a, int'($urandom_range(2) == 0), int'($urandom_range(2) == 0));
  endfunction

  task automatic send_cmd(input logic [IN_W-1:0] word);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] shift,
                           input logic [CFG_W-1:0] min_speed, input bit poke_unmapped);
    write_reg(REG_STEER_GAIN, gain);
    write_reg(REG_SHIFT_SPEED, shift);
    write_reg(REG_STEER_MIN_SPEED, min_speed);
    if (poke_unmapped) write_reg(REG_UNMAPPED, 8'($urandom_range(255)));
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    send_gap_pct   = 26;
    recv_stall_pct = 50;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: extremes, deadband and threshold edges, bumper patterns, saturation
    send_cmd(pack_cmd(0, 0, 0, 0));
    send_cmd(pack_cmd(255, 0, 0, 0));
    send_cmd(pack_cmd(-255, 0, 0, 0));
    send_cmd(pack_cmd(-256, 0, 0, 0));
    send_cmd(pack_cmd(255, 512, 0, 0));
    send_cmd(pack_cmd(255, -512, 0, 0));
    send_cmd(pack_cmd(-255, 512, 0, 0));
    send_cmd(pack_cmd(-255, -512, 0, 0));
    send_cmd(pack_cmd(100, 29, 0, 0));
    send_cmd(pack_cmd(100, 30, 0, 0));
    send_cmd(pack_cmd(100, -30, 0, 0));
    send_cmd(pack_cmd(25, 400, 0, 0));
    send_cmd(pack_cmd(26, 400, 0, 0));
    send_cmd(pack_cmd(-26, -400, 0, 0));
    send_cmd(pack_cmd(200, 1023, 0, 0));
    send_cmd(pack_cmd(200, -1024, 0, 0));
    send_cmd(pack_cmd(0, 300, 1, 0));
    send_cmd(pack_cmd(0, 300, 0, 1));
    send_cmd(pack_cmd(150, 0, 1, 0));
    send_cmd(pack_cmd(150, 0, 0, 1));
    send_cmd(pack_cmd(-150, 0, 1, 1));
    send_cmd(pack_cmd(255, 512, 1, 0));
    send_cmd(pack_cmd(-255, -512, 0, 1));
    send_cmd(pack_cmd(-256, -1024, 1, 1));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_gap_pct   = 26;
          recv_stall_pct = 50;
        end
        1: begin
          send_gap_pct   = 50;
          recv_stall_pct = 26;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (phase)
        0:       configure(8'd255, 8'd255, 8'd0, 1'b0);
        1:       configure(8'd0, 8'd0, 8'd255, 1'b1);
        default: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(160)), 1'b0);
      endcase
      for (int n = 0; n < PHASE_CMDS; n++) begin
        // stall the wheel side while commands keep coming so the pipeline backs up
        if (phase == 0 && n == 100) hold_req = 1'b1;
        // let the pipeline run empty before going on
        if (phase == 1 && n == 150) drain();
        send_cmd(rand_cmd());
      end
      drain();
    end

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
